/* rtl/core/vrt_pkg.sv */
`timescale 1ns / 1ps
// Package for the voxel ray traversal core: shared widths, axis codes
// and the divider status word. No dependencies.
package vrt_pkg;

    localparam int GP_W    = 16;
    localparam int STEPS_W = 26;
    localparam int DISC_W  = 64;
    localparam int INCR_W  = 48;
    localparam int DELTA_W = 17;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/vrt_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned dividend over
// the grid precision. Depends on vrt_pkg.
module vrt_div #(
    parameter int W = 23
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             dividend,
    input  logic [vrt_pkg::GP_W-1:0] divisor,
    output logic [W-1:0]             quotient,
    output logic [vrt_pkg::GP_W-1:0] remainder,
    output vrt_pkg::div_stat_t       stat
);
    import vrt_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]    quo_reg;
    logic [GP_W-1:0] rem_reg;
    logic [CW-1:0]   count_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [GP_W:0]   trial;
    logic            ge;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CW'(W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], ge};
            rem_reg <= ge ? GP_W'(trial - {1'b0, divisor}) : trial[GP_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/core/voxel_ray_traversal_3d_core.sv */
`timescale 1ns / 1ps
// Voxel ray traversal core: 3D integer DDA with a shared serial divider
// and a shared multiplier under one sequencer. Depends on vrt_pkg, vrt_div.
// Start word: six serial divisions and nine multiplies lie between accept
// and result. Step word: compare, update and output states in order.
// One word at a time; result held in an output register.
// rst_n clears the sequencer, cell, discriminators and step count; precision 16.
module voxel_ray_traversal_3d_core #(
    parameter int COORD_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [vrt_pkg::GP_W-1:0]          cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic signed [COORD_BITS-1:0]      start_x,
    input  logic signed [COORD_BITS-1:0]      start_y,
    input  logic signed [COORD_BITS-1:0]      start_z,
    input  logic signed [COORD_BITS-1:0]      end_x,
    input  logic signed [COORD_BITS-1:0]      end_y,
    input  logic signed [COORD_BITS-1:0]      end_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COORD_BITS-1:0]      cell_x,
    output logic signed [COORD_BITS-1:0]      cell_y,
    output logic signed [COORD_BITS-1:0]      cell_z,
    output logic [1:0]                        step_axis,
    output logic [vrt_pkg::STEPS_W-1:0]       steps_left,
    output logic                              past_end
);
    import vrt_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int DW    = CB - 1;
    localparam int OP_W  = (CB + 1 > DELTA_W) ? CB + 1 : DELTA_W;
    localparam int TOT_W = (CB + 3 > STEPS_W) ? CB + 3 : STEPS_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DGO   = 8'b0000_0010,
        S_DWAIT = 8'b0000_0100,
        S_PREP  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_CMP   = 8'b0010_0000,
        S_UPD   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [GP_W-1:0]       gp_reg;
    logic [GP_W-1:0]       p_eff;
    logic signed [CB-1:0]  a_reg [3];
    logic signed [CB-1:0]  b_reg [3];
    logic signed [CB-1:0]  first_reg [3];
    logic signed [CB-1:0]  last_reg [3];
    logic [GP_W-1:0]       rem_reg [3];
    logic [2:0]            d_idx_reg;
    logic [3:0]            m_idx_reg;
    logic [OP_W-1:0]       dir_reg [3];
    logic [DELTA_W-1:0]    delta_reg [3];
    logic [2*OP_W-1:0]     prod_reg;
    logic                  sign_reg [3];
    logic signed [CB-1:0]  cell_reg [3];
    logic [DISC_W-1:0]     disc_reg [3][2];
    logic [INCR_W-1:0]     incr_reg [3];
    logic [STEPS_W-1:0]    remain_reg;
    logic                  g10_reg, g20_reg, g21_reg;
    logic [1:0]            res_axis_reg;
    logic                  res_past_reg;
    logic                  out_valid_reg;

    logic signed [CB-1:0]  dv;
    logic [DW-1:0]         div_q;
    logic [GP_W-1:0]       div_r;
    div_stat_t             div_stat;
    logic                  div_start;
    logic signed [CB-1:0]  q_floor;
    logic [OP_W-1:0]       op_a, op_b;
    logic [1:0]            ax;
    logic                  in_acc, out_free;
    logic [TOT_W-1:0]      total;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign p_eff     = (gp_reg == '0) ? GP_W'(1) : gp_reg;
    assign div_start = (state_reg == S_DGO);

    always_comb
    begin
        case (d_idx_reg)
            3'd0:    dv = a_reg[0];
            3'd1:    dv = a_reg[1];
            3'd2:    dv = a_reg[2];
            3'd3:    dv = b_reg[0];
            3'd4:    dv = b_reg[1];
            default: dv = b_reg[2];
        endcase
    end

    vrt_div #(.W(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dv[CB-1] ? ~dv[DW-1:0] : dv[DW-1:0]),
        .divisor   (p_eff),
        .quotient  (div_q),
        .remainder (div_r),
        .stat      (div_stat)
    );

    assign q_floor = dv[CB-1] ? ~{1'b0, div_q} : {1'b0, div_q};

    always_comb
    begin
        total = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (b_reg[i] < a_reg[i])
                total = total + TOT_W'(unsigned'(CB'(first_reg[i] - last_reg[i])));
            else
                total = total + TOT_W'(unsigned'(CB'(last_reg[i] - first_reg[i])));
        end
    end

    always_comb
    begin
        case (m_idx_reg)
            4'd0:    begin op_a = dir_reg[0]; op_b = OP_W'(p_eff); end
            4'd1:    begin op_a = dir_reg[1]; op_b = OP_W'(p_eff); end
            4'd2:    begin op_a = dir_reg[2]; op_b = OP_W'(p_eff); end
            4'd3:    begin op_a = dir_reg[1]; op_b = OP_W'(delta_reg[0]); end
            4'd4:    begin op_a = dir_reg[2]; op_b = OP_W'(delta_reg[0]); end
            4'd5:    begin op_a = dir_reg[2]; op_b = OP_W'(delta_reg[1]); end
            4'd6:    begin op_a = dir_reg[0]; op_b = OP_W'(delta_reg[1]); end
            4'd7:    begin op_a = dir_reg[0]; op_b = OP_W'(delta_reg[2]); end
            4'd8:    begin op_a = dir_reg[1]; op_b = OP_W'(delta_reg[2]); end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    always_comb
    begin
        if (g10_reg)
            ax = g20_reg ? AXIS_X : AXIS_Z;
        else
            ax = g21_reg ? AXIS_Y : AXIS_Z;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc) state_next = cmd ? S_CMP : S_DGO;
            S_DGO:   state_next = S_DWAIT;
            S_DWAIT: if (div_stat.done) state_next = (d_idx_reg == 3'd5) ? S_PREP : S_DGO;
            S_PREP:  state_next = S_MUL;
            S_MUL:   if (m_idx_reg == 4'd9) state_next = S_FIN;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = S_FIN;
            S_FIN:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gp_reg        <= GP_W'(16);
            out_valid_reg <= 1'b0;
            d_idx_reg     <= '0;
            m_idx_reg     <= '0;
            remain_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sign_reg[i]    <= 1'b0;
                cell_reg[i]    <= '0;
                incr_reg[i]    <= '0;
                disc_reg[i][0] <= '0;
                disc_reg[i][1] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                gp_reg <= cfg_wr_data;
            if (state_reg == S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (in_acc)
                d_idx_reg <= '0;
            else if (state_reg == S_DWAIT && div_stat.done)
                d_idx_reg <= d_idx_reg + 3'd1;

            if (state_reg == S_PREP)
            begin
                m_idx_reg  <= '0;
                remain_reg <= total[STEPS_W-1:0];
                for (int i = 0; i < 3; i++)
                begin
                    sign_reg[i] <= b_reg[i] < a_reg[i];
                    cell_reg[i] <= first_reg[i];
                end
            end

            if (state_reg == S_MUL)
            begin
                m_idx_reg <= m_idx_reg + 4'd1;
                case (m_idx_reg)
                    4'd1:    incr_reg[0]    <= INCR_W'({prod_reg, 1'b0});
                    4'd2:    incr_reg[1]    <= INCR_W'({prod_reg, 1'b0});
                    4'd3:    incr_reg[2]    <= INCR_W'({prod_reg, 1'b0});
                    4'd4:    disc_reg[0][0] <= DISC_W'(prod_reg);
                    4'd5:    disc_reg[0][1] <= DISC_W'(prod_reg);
                    4'd6:    disc_reg[1][0] <= DISC_W'(prod_reg);
                    4'd7:    disc_reg[1][1] <= DISC_W'(prod_reg);
                    4'd8:    disc_reg[2][0] <= DISC_W'(prod_reg);
                    4'd9:    disc_reg[2][1] <= DISC_W'(prod_reg);
                    default: ;
                endcase
            end

            if (state_reg == S_UPD)
            begin
                if (remain_reg != '0)
                    remain_reg <= remain_reg - STEPS_W'(1);
                for (int i = 0; i < 3; i++)
                begin
                    if (ax == 2'(i))
                    begin
                        cell_reg[i]    <= cell_reg[i] + (sign_reg[i] ? {CB{1'b1}} : CB'(1));
                        disc_reg[i][0] <= disc_reg[i][0] + DISC_W'(incr_reg[(i + 1) % 3]);
                        disc_reg[i][1] <= disc_reg[i][1] + DISC_W'(incr_reg[(i + 2) % 3]);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            a_reg[0] <= start_x;
            a_reg[1] <= start_y;
            a_reg[2] <= start_z;
            b_reg[0] <= end_x;
            b_reg[1] <= end_y;
            b_reg[2] <= end_z;
        end

        if (state_reg == S_DWAIT && div_stat.done)
        begin
            case (d_idx_reg)
                3'd0:    begin first_reg[0] <= q_floor; rem_reg[0] <= div_r; end
                3'd1:    begin first_reg[1] <= q_floor; rem_reg[1] <= div_r; end
                3'd2:    begin first_reg[2] <= q_floor; rem_reg[2] <= div_r; end
                3'd3:    last_reg[0] <= q_floor;
                3'd4:    last_reg[1] <= q_floor;
                default: last_reg[2] <= q_floor;
            endcase
        end

        if (state_reg == S_PREP)
        begin
            res_axis_reg <= AXIS_NONE;
            res_past_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                if (b_reg[i] < a_reg[i])
                    dir_reg[i] <= OP_W'({a_reg[i][CB-1], a_reg[i]} - {b_reg[i][CB-1], b_reg[i]});
                else
                    dir_reg[i] <= OP_W'({b_reg[i][CB-1], b_reg[i]} - {a_reg[i][CB-1], a_reg[i]});
                if (a_reg[i][CB-1] ^ (b_reg[i] < a_reg[i]))
                    delta_reg[i] <= {rem_reg[i], 1'b1};
                else
                    delta_reg[i] <= {p_eff, 1'b0} - {rem_reg[i], 1'b0} - DELTA_W'(1);
            end
        end

        if (state_reg == S_MUL)
            prod_reg <= op_a * op_b;

        if (state_reg == S_CMP)
        begin
            g10_reg <= $signed(disc_reg[1][1]) > $signed(disc_reg[0][0]);
            g20_reg <= $signed(disc_reg[2][0]) > $signed(disc_reg[0][1]);
            g21_reg <= $signed(disc_reg[2][1]) > $signed(disc_reg[1][0]);
        end

        if (state_reg == S_UPD)
        begin
            res_axis_reg <= ax;
            res_past_reg <= (remain_reg == '0);
        end

        if (state_reg == S_FIN && out_free)
        begin
            cell_x     <= cell_reg[0];
            cell_y     <= cell_reg[1];
            cell_z     <= cell_reg[2];
            step_axis  <= res_axis_reg;
            steps_left <= remain_reg;
            past_end   <= res_past_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

/* rtl/core/vrt_checker.sv */
`timescale 1ns / 1ps
// Port-level checker for the voxel ray traversal core, bound to the core
// module itself. Depends on vrt_pkg.
module vrt_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [1:0]                  step_axis,
    input logic [vrt_pkg::STEPS_W-1:0] steps_left,
    input logic                        past_end,
    input logic signed [COORD_BITS-1:0] cell_x
);
    import vrt_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready held high after accepting a word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_x) && $stable(step_axis))
        else $error("result word changed while stalled");

    a_start_not_past: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_axis == AXIS_NONE |-> !past_end)
        else $error("start result flagged past end");

    a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && past_end |-> steps_left == '0)
        else $error("past end with steps remaining");

endmodule

bind voxel_ray_traversal_3d_core vrt_checker #(.COORD_BITS(COORD_BITS)) u_vrt_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for voxel_ray_traversal_3d_core: start and step words,
// a behavioural DDA predictor in a scoreboard class. Depends on vrt_pkg.
module testbench;
    import vrt_pkg::*;

    localparam int CB = 24;
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [CB-1:0] cx, cy, cz;
        logic [1:0] ax;
        logic [STEPS_W-1:0] left;
        logic past;
    } cell_word_t;

    class dda_scoreboard;
        logic [15:0] precision;
        bit neg [3];
        logic [CB-1:0] cur_cell [3];
        logic [63:0] disc [3][3];
        logic [63:0] incr [3];
        logic [STEPS_W-1:0] left;
        cell_word_t pending [$];
        int errors;
        int checked;

        function new();
            precision = 16'd16;
            for (int i = 0; i < 3; i++)
            begin
                neg[i] = 0;
                cur_cell[i] = '0;
                incr[i] = '0;
                for (int k = 0; k < 3; k++)
                    disc[i][k] = '0;
            end
            left = '0;
            errors = 0;
            checked = 0;
        endfunction

        function longint fl(longint v, longint p);
            if (v >= 0)
                return v / p;
            return (v + 1) / p - 1;
        endfunction

        function bit sgt(logic [63:0] a, logic [63:0] b);
            return $signed(a) > $signed(b);
        endfunction

        function void note_input(logic c, logic [CB-1:0] s [3], logic [CB-1:0] e [3]);
            cell_word_t w;
            longint p, a, b, first, last, m, fm;
            logic [63:0] dir [3];
            logic [63:0] dlt [3];
            logic [63:0] total;
            int ax, k1, k2;
            if (c == CMD_START)
            begin
                p = (precision == 0) ? 1 : longint'(precision);
                total = 0;
                for (int i = 0; i < 3; i++)
                begin
                    a = longint'($signed(s[i]));
                    b = longint'($signed(e[i]));
                    neg[i] = b < a;
                    first = fl(a, p);
                    last = fl(b, p);
                    m = neg[i] ? -a - 1 : a;
                    fm = fl(m, p);
                    dir[i] = neg[i] ? a - b : b - a;
                    total += neg[i] ? first - last : last - first;
                    dlt[i] = 2 * (fm * p + p) - (2 * m + 1);
                    incr[i] = 2 * dir[i] * p;
                    cur_cell[i] = first[CB-1:0];
                end
                for (int i = 0; i < 3; i++)
                begin
                    disc[i][(i + 1) % 3] = dlt[i] * dir[(i + 1) % 3];
                    disc[i][(i + 2) % 3] = dlt[i] * dir[(i + 2) % 3];
                end
                left = total[STEPS_W-1:0];
                w.ax = AXIS_NONE;
                w.past = 0;
            end
            else
            begin
                if (sgt(disc[1][0], disc[0][1]))
                    ax = sgt(disc[2][0], disc[0][2]) ? 0 : 2;
                else
                    ax = sgt(disc[2][1], disc[1][2]) ? 1 : 2;
                k1 = (ax + 1) % 3;
                k2 = (ax + 2) % 3;
                cur_cell[ax] = neg[ax] ? cur_cell[ax] - CB'(1) : cur_cell[ax] + CB'(1);
                disc[ax][k1] += incr[k1];
                disc[ax][k2] += incr[k2];
                w.past = left == 0;
                if (!w.past)
                    left--;
                w.ax = ax[1:0];
            end
            w.cx = cur_cell[0];
            w.cy = cur_cell[1];
            w.cz = cur_cell[2];
            w.left = left;
            pending.push_back(w);
        endfunction

        function void check_result(cell_word_t got);
            cell_word_t w;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            w = pending.pop_front();
            if (w != got)
            begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp cell %0d %0d %0d ax %0d left %0d past %0d,",
                        " got cell %0d %0d %0d ax %0d left %0d past %0d"},
                        $signed(w.cx), $signed(w.cy), $signed(w.cz), w.ax, w.left, w.past,
                        $signed(got.cx), $signed(got.cy), $signed(got.cz), got.ax,
                        got.left, got.past);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_wr_en = 0;
    logic [GP_W-1:0] cfg_wr_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic cmd = 0;
    logic signed [CB-1:0] start_x = 0, start_y = 0, start_z = 0;
    logic signed [CB-1:0] end_x = 0, end_y = 0, end_z = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [CB-1:0] cell_x, cell_y, cell_z;
    logic [1:0] step_axis;
    logic [STEPS_W-1:0] steps_left;
    logic past_end;

    dda_scoreboard sb;
    bit calm = 0;
    int idle_cycles = 0;
    int starts = 0, steps = 0;

    always #5 clk = ~clk;

    voxel_ray_traversal_3d_core #(.COORD_BITS(CB)) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .end_x(end_x), .end_y(end_y), .end_z(end_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
        .step_axis(step_axis), .steps_left(steps_left), .past_end(past_end)
    );

    // drain side with random stall bursts
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge clk);
            end
            out_ready <= 1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result({cell_x, cell_y, cell_z, step_axis, steps_left, past_end});
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("voxel_ray_traversal_3d_core verification failed");
            $finish;
        end
    end

    task automatic send_word(logic c, logic [CB-1:0] s [3], logic [CB-1:0] e [3]);
        int n;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 0;
            n = $urandom_range(1, 8);
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        cmd <= c;
        start_x <= s[0]; start_y <= s[1]; start_z <= s[2];
        end_x <= e[0]; end_y <= e[1]; end_z <= e[2];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(c, s, e);
        if (c == CMD_START)
            starts++;
        else
            steps++;
    endtask

    task automatic send_step();
        logic [CB-1:0] s [3];
        logic [CB-1:0] e [3];
        for (int i = 0; i < 3; i++)
        begin
            s[i] = CB'($urandom);
            e[i] = CB'($urandom);
        end
        send_word(CMD_STEP, s, e);
    endtask

    task automatic send_ray(int span);
        logic [CB-1:0] s [3];
        logic [CB-1:0] e [3];
        int d;
        for (int i = 0; i < 3; i++)
        begin
            s[i] = CB'($urandom);
            d = $urandom_range(0, 2 * span) - span;
            e[i] = CB'(s[i] + d);
        end
        send_word(CMD_START, s, e);
    endtask

    task automatic settle_and_write(logic [GP_W-1:0] v);
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        sb.precision = v;
    endtask

    task automatic send_fixed(logic [CB-1:0] a, logic [CB-1:0] b);
        logic [CB-1:0] s [3];
        logic [CB-1:0] e [3];
        for (int i = 0; i < 3; i++)
        begin
            s[i] = a;
            e[i] = b;
        end
        send_word(CMD_START, s, e);
    endtask

    initial
    begin
        logic [GP_W-1:0] precs [6];
        int n, span;
        sb = new();
        precs = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd256, 16'd16};
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: steps from reset, extremes, ties
        send_step();
        send_step();
        send_fixed(24'h800000, 24'h7FFFFF);
        repeat (3) send_step();
        send_fixed(24'h7FFFFF, 24'h800000);
        repeat (3) send_step();
        send_fixed(24'h000000, 24'h000000);
        send_step();
        send_fixed(24'hFFFFFF, 24'h000040);
        repeat (6) send_step();
        settle_and_write(16'd0);
        send_fixed(24'hFFFFF0, 24'h000004);
        repeat (4) send_step();

        for (int ph = 0; ph < 6; ph++)
        begin
            settle_and_write(precs[ph]);
            for (int r = 0; r < 25; r++)
            begin
                if (ph == 5 && r > 12)
                    calm = 1;
                span = ($urandom_range(0, 9) == 0) ? 8388607 : $urandom_range(0, 200);
                if ($urandom_range(0, 7) == 0)
                    send_step();
                send_ray(span);
                n = $urandom_range(0, 10);
                repeat (n) send_step();
            end
        end

        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("covered %0d start words and %0d step words over six precisions,",
            starts, steps);
        $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("voxel_ray_traversal_3d_core verification clean");
        else
            $display("voxel_ray_traversal_3d_core verification failed");
        $finish;
    end
endmodule
